[rtl/core/text_console_cursor_controller_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the text console cursor controller
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define TCC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tcc assertion failed");

// Condition in one cycle implies a consequence in the next cycle
`define TCC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcc assertion failed");

`endif

[rtl/core/tcc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor controller.
// ---------------------------------------------------------------------------
package tcc_pkg;

  // Default parameter values
  localparam int unsigned DEF_MAX_COLUMNS = 128;
  localparam int unsigned DEF_MAX_ROWS    = 50;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // Hard limits of the cursor fields
  localparam int unsigned COL_HARD_LIM = 128;
  localparam int unsigned ROW_HARD_LIM = 64;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 2'd1;

  // Register reset values
  localparam logic [7:0] RST_TEXT_COLUMNS = 8'd128;
  localparam logic [5:0] RST_TEXT_ROWS    = 6'd50;

  // Character codes
  localparam logic [7:0] CH_BS        = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_FIRST_PRN = 8'd32;
  localparam logic [6:0] GLYPH_SPACE  = 7'd32;
  localparam logic [7:0] TAB_STOP     = 8'd8;

  // Input kinds
  localparam logic KIND_PUT   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Drawing commands
  typedef enum logic [2:0] {
    CMD_ERASE  = 3'd0,
    CMD_GLYPH  = 3'd1,
    CMD_SCROLL = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // Bit positions in a job's command mask, in emission order
  localparam int unsigned JB_ERASE  = 0;
  localparam int unsigned JB_GLYPH  = 1;
  localparam int unsigned JB_SCROLL = 2;
  localparam int unsigned JB_CURSOR = 3;
  localparam int unsigned JB_CLEAR  = 4;
  localparam int unsigned JB_W      = 5;

  // One classified item, holding everything its commands need
  typedef struct packed {
    logic [JB_W-1:0] mask;
    logic [6:0]      old_col;
    logic [5:0]      old_row;
    logic [6:0]      glyph_col;
    logic [5:0]      glyph_row;
    logic [6:0]      glyph;
    logic [5:0]      scroll_row;
    logic [6:0]      new_col;
    logic [5:0]      new_row;
  } job_t;

endpackage

[rtl/core/text_console_cursor_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_cursor_controller
// Keeps the text cursor and emits drawing commands for a character renderer.
// ---------------------------------------------------------------------------
// Input beats (s_axis) carry a character code in tdata and the kind in tuser
// (0 put character, 1 clear screen). Each beat yields up to four commands on
// m_axis: erase cursor, draw glyph, scroll, draw cursor; tlast marks the final
// command of a beat. Ignored control codes are taken and give no command.
// A beat's first command passes through the job queue and the job register to
// the output register. The command port moves one beat per cycle while the
// receiver is ready, so an item takes one to four beats; output is the limit.
// The front part accepts a beat every cycle while the job queue has room,
// also while the output is stalled; when the queue fills, s_axis_tready drops.
// Config writes (cfg_*) take index 0 text_columns or 1 text_rows, are always
// ready, home the cursor and must be issued while no commands are pending.
// Reset (rst_ni low) empties the queue and output, homes the cursor and sets
// 128 columns by 50 rows.
// ---------------------------------------------------------------------------
module text_console_cursor_controller
  import tcc_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] char_code
  input  logic                 s_axis_tuser,  // [0] kind
  // command stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // [6:0] column, [12:7] row, [19:13] glyph
  output logic [2:0]           m_axis_tuser,  // [2:0] command
  output logic                 m_axis_tlast,
  // config writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  job_t       push_data, pop_data;
  logic       push, full, pop, empty;
  cmd_e       out_cmd;
  logic [6:0] out_col, out_glyph;
  logic [5:0] out_row;

  assign cfg_ready_o = 1'b1;

  tcc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .char_code_i (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tcc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cmd_o   (out_cmd),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_glyph_o (out_glyph),
    .out_last_o  (m_axis_tlast)
  );

  // Output packing
  assign m_axis_tdata = {4'd0, out_glyph, out_row, out_col};
  assign m_axis_tuser = 3'(out_cmd);

endmodule

[rtl/core/tcc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_front
// Accepts input beats and config writes, keeps the cursor and turns each
// item into one job for the command queue.
// ---------------------------------------------------------------------------
`include "text_console_cursor_controller_defines.svh"

module tcc_front
  import tcc_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [7:0]           char_code_i,
  // config writes
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // queue side
  output logic                 push_o,
  output job_t                 push_data_o,
  input  logic                 full_i
);

  localparam int unsigned COL_LIM = (MAX_COLUMNS < COL_HARD_LIM) ? MAX_COLUMNS : COL_HARD_LIM;
  localparam int unsigned ROW_LIM = (MAX_ROWS < ROW_HARD_LIM) ? MAX_ROWS : ROW_HARD_LIM;

  logic [7:0] cols_q, cols_d;
  logic [5:0] rows_q, rows_d;
  logic [6:0] cur_col_q, cur_col_d;
  logic [5:0] cur_row_q, cur_row_d;

  logic [7:0] cols_eff;
  logic [6:0] rows_eff;
  logic [7:0] col8;
  logic [6:0] row7;
  logic       accept;

  // Effective sizes, saturated to the supported range
  always_comb begin
    if (cols_q == 8'd0) begin
      cols_eff = 8'd1;
    end else if (cols_q > 8'(COL_LIM)) begin
      cols_eff = 8'(COL_LIM);
    end else begin
      cols_eff = cols_q;
    end
    if (rows_q == 6'd0) begin
      rows_eff = 7'd1;
    end else if ({1'b0, rows_q} > 7'(ROW_LIM)) begin
      rows_eff = 7'(ROW_LIM);
    end else begin
      rows_eff = {1'b0, rows_q};
    end
  end

  assign col8       = {1'b0, cur_col_q};
  assign row7       = {1'b0, cur_row_q};
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the character and move the cursor
  logic       is_bs, is_tab, is_lf, is_cr, is_prn, ignore;
  logic       wrap, scrolled;
  logic [6:0] mv_col;
  logic [5:0] mv_row;
  logic [7:0] tab_col, inc_col;
  logic [6:0] row_inc;
  logic [6:0] nx_col;
  logic [5:0] nx_row;
  job_t       job;

  always_comb begin
    is_bs   = (char_code_i == CH_BS);
    is_tab  = (char_code_i == CH_TAB);
    is_lf   = (char_code_i == CH_LF);
    is_cr   = (char_code_i == CH_CR);
    is_prn  = (char_code_i >= CH_FIRST_PRN);
    ignore  = !is_prn && !is_bs && !is_tab && !is_lf && !is_cr;
    tab_col = (col8 + TAB_STOP) & ~(TAB_STOP - 8'd1);
    inc_col = col8 + 8'd1;
    mv_col  = cur_col_q;
    mv_row  = cur_row_q;
    wrap    = 1'b0;

    priority if (is_lf) begin
      wrap = 1'b1;
    end else if (is_cr) begin
      mv_col = 7'd0;
    end else if (is_tab) begin
      if (tab_col >= cols_eff) begin
        wrap = 1'b1;
      end else begin
        mv_col = tab_col[6:0];
      end
    end else if (is_bs) begin
      if (cur_col_q != 7'd0) begin
        mv_col = cur_col_q - 7'd1;
      end else if (cur_row_q != 6'd0) begin
        mv_row = cur_row_q - 6'd1;
        mv_col = 7'(cols_eff - 8'd1);
      end
    end else begin
      if (inc_col >= cols_eff) begin
        wrap = 1'b1;
      end else begin
        mv_col = inc_col[6:0];
      end
    end

    // Start of the next row, scrolling at the bottom
    row_inc  = row7 + 7'd1;
    scrolled = 1'b0;
    nx_col   = mv_col;
    nx_row   = mv_row;
    if (wrap) begin
      nx_col = 7'd0;
      if (row_inc >= rows_eff) begin
        nx_row   = 6'(rows_eff - 7'd1);
        scrolled = 1'b1;
      end else begin
        nx_row = row_inc[5:0];
      end
    end

    // Job contents
    job            = '0;
    job.old_col    = cur_col_q;
    job.old_row    = cur_row_q;
    job.scroll_row = 6'(rows_eff - 7'd1);
    job.new_col    = nx_col;
    job.new_row    = nx_row;
    if (is_bs) begin
      job.glyph_col = mv_col;
      job.glyph_row = mv_row;
      job.glyph     = GLYPH_SPACE;
    end else begin
      job.glyph_col = cur_col_q;
      job.glyph_row = cur_row_q;
      job.glyph     = char_code_i[7] ? 7'd0 : char_code_i[6:0];
    end
    if (kind_i == KIND_CLEAR) begin
      job.mask           = '0;
      job.mask[JB_CLEAR] = 1'b1;
    end else begin
      job.mask[JB_ERASE]  = 1'b1;
      job.mask[JB_GLYPH]  = is_bs || is_prn;
      job.mask[JB_SCROLL] = scrolled;
      job.mask[JB_CURSOR] = !(is_lf && scrolled);
    end
  end

  assign push_o      = accept && ((kind_i == KIND_CLEAR) || !ignore);
  assign push_data_o = job;

  // Next cursor and register values
  always_comb begin
    cols_d    = cols_q;
    rows_d    = rows_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (cfg_valid_i && (cfg_index_i == REG_TEXT_COLUMNS || cfg_index_i == REG_TEXT_ROWS)) begin
      if (cfg_index_i == REG_TEXT_COLUMNS) begin
        cols_d = cfg_data_i;
      end else begin
        rows_d = cfg_data_i[5:0];
      end
      cur_col_d = 7'd0;
      cur_row_d = 6'd0;
    end else if (accept) begin
      if (kind_i == KIND_CLEAR) begin
        cur_col_d = 7'd0;
        cur_row_d = 6'd0;
      end else if (!ignore) begin
        cur_col_d = nx_col;
        cur_row_d = nx_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= RST_TEXT_COLUMNS;
      rows_q    <= RST_TEXT_ROWS;
      cur_col_q <= 7'd0;
      cur_row_q <= 6'd0;
    end else begin
      cols_q    <= cols_d;
      rows_q    <= rows_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

  // Cursor always stays inside the text area
  `TCC_ASSERT(a_col_inside, clk_i, rst_ni, col8 < cols_eff)
  `TCC_ASSERT(a_row_inside, clk_i, rst_ni, row7 < rows_eff)

endmodule

[rtl/core/tcc_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_fifo
// Short job queue between the front and back parts (DEPTH of 2 or more).
// ---------------------------------------------------------------------------
`include "text_console_cursor_controller_defines.svh"

module tcc_fifo
  import tcc_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TCC_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `TCC_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o))

endmodule

[rtl/core/tcc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcc_back
// Takes jobs from the queue and plays out their commands, one beat per
// cycle while out_ready_i allows, through a registered output stage.
// ---------------------------------------------------------------------------
`include "text_console_cursor_controller_defines.svh"

module tcc_back
  import tcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // queue side
  input  job_t       pop_data_i,
  input  logic       empty_i,
  output logic       pop_o,
  // command stream
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_e       out_cmd_o,
  output logic [6:0] out_col_o,
  output logic [5:0] out_row_o,
  output logic [6:0] out_glyph_o,
  output logic       out_last_o
);

  job_t            job_q;
  logic [JB_W-1:0] mask_q, mask_d, mask_nx;
  logic            out_vld_q, out_vld_d;
  cmd_e            out_cmd_q, cmd_sel;
  logic [6:0]      out_col_q, col_sel;
  logic [5:0]      out_row_q, row_sel;
  logic [6:0]      out_glyph_q, glyph_sel;
  logic            out_last_q;
  logic            out_free, advance, retire;

  // Step control: emit the lowest pending command, fetch the next job
  always_comb begin
    out_free = !out_vld_q || out_ready_i;
    advance  = out_free && (mask_q != '0);
    mask_nx  = mask_q & (mask_q - JB_W'(1));
    retire   = (mask_q == '0) || (advance && (mask_nx == '0));
    pop_o    = retire && !empty_i;

    mask_d = mask_q;
    if (pop_o) begin
      mask_d = pop_data_i.mask;
    end else if (advance) begin
      mask_d = mask_nx;
    end

    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Fields of the selected command
  always_comb begin
    glyph_sel = 7'd0;
    priority if (mask_q[JB_CLEAR]) begin
      cmd_sel = CMD_CLEAR;
      col_sel = 7'd0;
      row_sel = 6'd0;
    end else if (mask_q[JB_ERASE]) begin
      cmd_sel = CMD_ERASE;
      col_sel = job_q.old_col;
      row_sel = job_q.old_row;
    end else if (mask_q[JB_GLYPH]) begin
      cmd_sel   = CMD_GLYPH;
      col_sel   = job_q.glyph_col;
      row_sel   = job_q.glyph_row;
      glyph_sel = job_q.glyph;
    end else if (mask_q[JB_SCROLL]) begin
      cmd_sel = CMD_SCROLL;
      col_sel = 7'd0;
      row_sel = job_q.scroll_row;
    end else begin
      cmd_sel = CMD_CURSOR;
      col_sel = job_q.new_col;
      row_sel = job_q.new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Job and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= pop_data_i;
    end
    if (advance) begin
      out_cmd_q   <= cmd_sel;
      out_col_q   <= col_sel;
      out_row_q   <= row_sel;
      out_glyph_q <= glyph_sel;
      out_last_q  <= (mask_nx == '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_cmd_o   = out_cmd_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_glyph_o = out_glyph_q;
  assign out_last_o  = out_last_q;

  // A stalled job keeps its pending commands
  `TCC_ASSERT_NEXT(a_mask_hold, clk_i, rst_ni, (mask_q != '0) && !out_free, mask_q == $past(mask_q))
  // A clear is always the only command of its item
  `TCC_ASSERT(a_clear_last, clk_i, rst_ni, (out_vld_q && out_cmd_q == CMD_CLEAR) |-> out_last_q)

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench of the text console cursor controller.
// ---------------------------------------------------------------------------
// A directed table walks the corner cases: clear, wide glyph codes, ignored
// control codes, backspace at home and across rows, tab, newline with and
// without scroll, and the smallest and largest text areas. Random phases
// follow with new area sizes and with idling on either stream. Every command beat
// is compared field by field against typed table commands or the bench's cursor model.
// ---------------------------------------------------------------------------
module tb;
  import tcc_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 30;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  typedef enum logic {ROW_PUT, ROW_CFG} row_op_e;

  // One drawing command as it should appear on the command stream
  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] col;
    logic [5:0] row;
    logic [6:0] glyph;
  } cell_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] col;
    logic [5:0] row;
    logic [6:0] glyph;
    logic       last;
  } draw_cmd_t;

  // Directed row: a character beat or a register write, with the commands
  // typed in where they are obvious
  typedef struct packed {
    row_op_e              op;
    logic                 kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;
    logic                 typed;
    logic [2:0]           n;
    cell_t [0:3]          cmds;
  } dir_row_t;

  localparam cell_t NC = '{CMD_ERASE, 7'd0, 6'd0, 7'd0};
  localparam cell_t CLR = '{CMD_CLEAR, 7'd0, 6'd0, 7'd0};
  localparam cell_t E00 = '{CMD_ERASE, 7'd0, 6'd0, 7'd0};
  localparam cell_t E01 = '{CMD_ERASE, 7'd0, 6'd1, 7'd0};
  localparam cell_t K00 = '{CMD_CURSOR, 7'd0, 6'd0, 7'd0};
  localparam cell_t K01 = '{CMD_CURSOR, 7'd0, 6'd1, 7'd0};
  localparam cell_t S00 = '{CMD_SCROLL, 7'd0, 6'd0, 7'd0};
  localparam cell_t S01 = '{CMD_SCROLL, 7'd0, 6'd1, 7'd0};

  localparam dir_row_t DIR_TAB [32] = '{
    // reset area 128 x 50, cursor home
    '{ROW_PUT, KIND_CLEAR, '0, 8'h00, 1'b1, 3'd1, '{CLR, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h41, 1'b1, 3'd3,
      '{E00, '{CMD_GLYPH, 7'd0, 6'd0, 7'd65}, '{CMD_CURSOR, 7'd1, 6'd0, 7'd0}, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'hFF, 1'b1, 3'd3,
      '{'{CMD_ERASE, 7'd1, 6'd0, 7'd0}, '{CMD_GLYPH, 7'd1, 6'd0, 7'd0},
        '{CMD_CURSOR, 7'd2, 6'd0, 7'd0}, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h00, 1'b1, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_BS, 1'b1, 3'd3,
      '{'{CMD_ERASE, 7'd2, 6'd0, 7'd0}, '{CMD_GLYPH, 7'd1, 6'd0, 7'd32},
        '{CMD_CURSOR, 7'd1, 6'd0, 7'd0}, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_CR, 1'b1, 3'd2,
      '{'{CMD_ERASE, 7'd1, 6'd0, 7'd0}, K00, NC, NC}},
    // backspace at home draws a space in place
    '{ROW_PUT, KIND_PUT, '0, CH_BS, 1'b1, 3'd3,
      '{E00, '{CMD_GLYPH, 7'd0, 6'd0, 7'd32}, K00, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_TAB, 1'b1, 3'd2,
      '{E00, '{CMD_CURSOR, 7'd8, 6'd0, 7'd0}, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_LF, 1'b1, 3'd2,
      '{'{CMD_ERASE, 7'd8, 6'd0, 7'd0}, K01, NC, NC}},
    // backspace at column 0 goes to the end of the row above
    '{ROW_PUT, KIND_PUT, '0, CH_BS, 1'b1, 3'd3,
      '{E01, '{CMD_GLYPH, 7'd127, 6'd0, 7'd32}, '{CMD_CURSOR, 7'd127, 6'd0, 7'd0}, NC}},
    // glyph in the last column wraps without scroll
    '{ROW_PUT, KIND_PUT, '0, 8'h7E, 1'b1, 3'd3,
      '{'{CMD_ERASE, 7'd127, 6'd0, 7'd0}, '{CMD_GLYPH, 7'd127, 6'd0, 7'd126},
        K01, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h7F, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h1F, 1'b1, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h80, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_CLEAR, '0, 8'hFF, 1'b1, 3'd1, '{CLR, NC, NC, NC}},
    // 8 x 2 area
    '{ROW_CFG, KIND_PUT, REG_TEXT_COLUMNS, 8'd8, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_CFG, KIND_PUT, REG_TEXT_ROWS, 8'd2, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_LF, 1'b1, 3'd2, '{E00, K01, NC, NC}},
    // newline on the bottom row scrolls and skips the redraw
    '{ROW_PUT, KIND_PUT, '0, CH_LF, 1'b1, 3'd2, '{E01, S01, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_TAB, 1'b1, 3'd3, '{E01, S01, K01, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h51, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    // zero counts saturate to a 1 x 1 area
    '{ROW_CFG, KIND_PUT, REG_TEXT_COLUMNS, 8'd0, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_CFG, KIND_PUT, REG_TEXT_ROWS, 8'd0, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h61, 1'b1, 3'd4,
      '{E00, '{CMD_GLYPH, 7'd0, 6'd0, 7'd97}, S00, K00}},
    '{ROW_PUT, KIND_PUT, '0, CH_BS, 1'b1, 3'd3,
      '{E00, '{CMD_GLYPH, 7'd0, 6'd0, 7'd32}, K00, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_TAB, 1'b1, 3'd3, '{E00, S00, K00, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_LF, 1'b1, 3'd2, '{E00, S00, NC, NC}},
    // oversized counts saturate to the maximum area
    '{ROW_CFG, KIND_PUT, REG_TEXT_COLUMNS, 8'd255, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_CFG, KIND_PUT, REG_TEXT_ROWS, 8'd63, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, CH_TAB, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    // write to an unused index leaves the cursor where it is
    '{ROW_CFG, KIND_PUT, REG_SPARE, 8'hA5, 1'b0, 3'd0, '{NC, NC, NC, NC}},
    '{ROW_PUT, KIND_PUT, '0, 8'h7A, 1'b0, 3'd0, '{NC, NC, NC, NC}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] char_code
  logic                 s_axis_tuser;   // [0] kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;   // [6:0] column, [12:7] row, [19:13] glyph
  logic [2:0]           m_axis_tuser;   // [2:0] command
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;

  // Cursor model state and register copies
  logic [7:0] columns_reg;
  logic [5:0] rows_reg;
  int         cur_col;
  int         cur_row;

  draw_cmd_t  planned_cmds[$];
  draw_cmd_t  pending_cmds[$];
  int         mismatch_count = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;

  text_console_cursor_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Receiver backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic void add_cmd(cmd_e cmd, int col, int row, logic [6:0] glyph);
    draw_cmd_t c;
    c.cmd   = cmd;
    c.col   = 7'(col);
    c.row   = 6'(row);
    c.glyph = glyph;
    c.last  = 1'b0;
    planned_cmds.push_back(c);
  endfunction

  // Move to the start of the next row; true when the area scrolls
  function automatic bit step_row(int rows);
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows) begin
      cur_row = rows - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Commands caused by one input beat; updates the cursor
  function automatic void plan_commands(logic kind, logic [7:0] code);
    int        cols;
    int        rows;
    bit        scrolled;
    bit        redraw;
    draw_cmd_t tail;
    planned_cmds.delete();
    cols = columns_reg;
    rows = rows_reg;
    if (cols < 1) cols = 1;
    if (cols > DEF_MAX_COLUMNS) cols = DEF_MAX_COLUMNS;
    if (cols > COL_HARD_LIM) cols = COL_HARD_LIM;
    if (rows < 1) rows = 1;
    if (rows > DEF_MAX_ROWS) rows = DEF_MAX_ROWS;
    if (rows > ROW_HARD_LIM) rows = ROW_HARD_LIM;
    scrolled = 1'b0;
    redraw   = 1'b1;
    if (kind == KIND_CLEAR) begin
      cur_col = 0;
      cur_row = 0;
      add_cmd(CMD_CLEAR, 0, 0, '0);
    end else if (code >= CH_FIRST_PRN || code == CH_LF || code == CH_CR ||
                 code == CH_TAB || code == CH_BS) begin
      add_cmd(CMD_ERASE, cur_col, cur_row, '0);
      case (code)
        CH_LF: begin
          scrolled = step_row(rows);
          redraw   = !scrolled;
        end
        CH_CR: cur_col = 0;
        CH_TAB: begin
          cur_col = (cur_col + int'(TAB_STOP)) & ~(int'(TAB_STOP) - 1);
          if (cur_col >= cols) scrolled = step_row(rows);
        end
        CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = cols - 1;
          end
          add_cmd(CMD_GLYPH, cur_col, cur_row, GLYPH_SPACE);
        end
        default: begin
          // codes with the top bit set draw glyph 0
          add_cmd(CMD_GLYPH, cur_col, cur_row, code[7] ? 7'd0 : code[6:0]);
          cur_col++;
          if (cur_col >= cols) scrolled = step_row(rows);
        end
      endcase
      if (scrolled) add_cmd(CMD_SCROLL, 0, rows - 1, '0);
      if (redraw) add_cmd(CMD_CURSOR, cur_col, cur_row, '0);
    end
    if (planned_cmds.size() > 0) begin
      tail = planned_cmds.pop_back();
      tail.last = 1'b1;
      planned_cmds.push_back(tail);
    end
  endfunction

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t %s", $realtime, msg);
  endfunction

  // Command checker
  always @(posedge clk_i) begin
    draw_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        flag_error($sformatf("unexpected command beat: cmd %0d col %0d row %0d",
                             m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[12:7]));
      end else begin
        want = pending_cmds.pop_front();
        if (m_axis_tuser !== want.cmd || m_axis_tdata[6:0] !== want.col ||
            m_axis_tdata[12:7] !== want.row || m_axis_tdata[19:13] !== want.glyph ||
            m_axis_tdata[23:20] !== 4'd0 || m_axis_tlast !== want.last) begin
          flag_error($sformatf({"mismatch: expected cmd %0d col %0d row %0d glyph %0d",
                                " last %0d, got cmd %0d col %0d row %0d glyph %0d",
                                " last %0d pad %0h"},
                               want.cmd, want.col, want.row, want.glyph, want.last,
                               m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[12:7],
                               m_axis_tdata[19:13], m_axis_tlast, m_axis_tdata[23:20]));
        end
      end
    end
  end

  // One character beat, with random sender gaps ahead of it
  task automatic send_beat(input logic kind, input logic [7:0] code);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = code;
    do @(posedge clk_i); while (!s_axis_tready);
    plan_commands(kind, code);
  endtask

  // Stop sending and let every pending command drain
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TEXT_COLUMNS || idx == REG_TEXT_ROWS) begin
      if (idx == REG_TEXT_COLUMNS) columns_reg = value;
      else rows_reg = value[5:0];
      cur_col = 0;
      cur_row = 0;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Limit on the whole run
  initial begin
    #1_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic       kind;
    logic [7:0] code;
    int         r;
    int         made;
    draw_cmd_t  c;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_PUT;
    m_axis_tready = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_TEXT_COLUMNS;
    cfg_data_i    = '0;
    columns_reg   = RST_TEXT_COLUMNS;
    rows_reg      = RST_TEXT_ROWS;
    cur_col       = 0;
    cur_row       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      if (DIR_TAB[i].op == ROW_CFG) begin
        settle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
      end else begin
        send_beat(DIR_TAB[i].kind, DIR_TAB[i].data);
        if (DIR_TAB[i].typed) begin
          for (int j = 0; j < DIR_TAB[i].n; j++) begin
            c.cmd   = DIR_TAB[i].cmds[j].cmd;
            c.col   = DIR_TAB[i].cmds[j].col;
            c.row   = DIR_TAB[i].cmds[j].row;
            c.glyph = DIR_TAB[i].cmds[j].glyph;
            c.last  = (j == DIR_TAB[i].n - 1);
            pending_cmds.push_back(c);
          end
        end else begin
          foreach (planned_cmds[j]) pending_cmds.push_back(planned_cmds[j]);
        end
      end
    end

    // Random phases, each with a fresh area size and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      settle();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      case (p % 4)
        1: tx_idle_pct = 77;
        2: rx_stall_pct = 77;
        3: begin
          tx_idle_pct  = 26;
          rx_stall_pct = 26;
        end
        default: ;
      endcase
      if ($urandom_range(3) == 0) begin
        write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(1)), 8'($urandom));
      end
      case ($urandom_range(7))
        0: write_reg(REG_TEXT_COLUMNS, 8'd0);
        1: write_reg(REG_TEXT_COLUMNS, 8'd1);
        2: write_reg(REG_TEXT_COLUMNS, RST_TEXT_COLUMNS);
        3: write_reg(REG_TEXT_COLUMNS, 8'($urandom));
        default: write_reg(REG_TEXT_COLUMNS, 8'($urandom_range(16, 2)));
      endcase
      case ($urandom_range(7))
        0: write_reg(REG_TEXT_ROWS, 8'd0);
        1: write_reg(REG_TEXT_ROWS, 8'd1);
        2: write_reg(REG_TEXT_ROWS, 8'(RST_TEXT_ROWS));
        3: write_reg(REG_TEXT_ROWS, 8'($urandom_range(63)));
        default: write_reg(REG_TEXT_ROWS, 8'($urandom_range(6, 2)));
      endcase

      made = 0;
      while (made < PHASE_ITEMS) begin
        r    = $urandom_range(99);
        kind = KIND_PUT;
        code = 8'($urandom_range(255, 32));
        if (r < 8) begin
          kind = KIND_CLEAR;
          code = 8'($urandom);
        end else if (r < 30) begin
          case ($urandom_range(3))
            0: code = CH_BS;
            1: code = CH_TAB;
            2: code = CH_LF;
            default: code = CH_CR;
          endcase
        end else if (r < 38) begin
          code = 8'($urandom_range(31));
        end
        send_beat(kind, code);
        foreach (planned_cmds[j]) pending_cmds.push_back(planned_cmds[j]);
        if (planned_cmds.size() > 0) made++;
        // sender holds off mid-phase until the output has drained
        if (p % 2 == 1 && made == PHASE_ITEMS / 2 && planned_cmds.size() > 0) settle();
      end
    end

    settle();
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[text_console_cursor_controller.f]
+incdir+rtl/core
rtl/core/tcc_pkg.sv
rtl/core/tcc_front.sv
rtl/core/tcc_fifo.sv
rtl/core/tcc_back.sv
rtl/core/text_console_cursor_controller.sv
bench/tb.sv
